FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the height map line parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is asserted.
`define HMLTP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define HMLTP_NEVER(lbl, clk, rstn, cond, msg) \
	`HMLTP_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: rtl/core/hmltp_pkg.sv
// Types and constants for the height map line token parser.
// No dependencies; imported by hmltp_parse and the top level.
`default_nettype none

package hmltp_pkg;

	localparam int unsigned ResultQueueDepth = 4;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	// Input item kinds
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	// Result word kinds
	localparam logic RES_POINT  = 1'b0;
	localparam logic RES_STATUS = 1'b1;

	localparam logic [3:0]  SUFFIX_LEN    = 4'd9;
	localparam logic [3:0]  HEX_START     = 4'd3;
	localparam logic [31:0] COLOR_WHITE   = 32'h00FF_FFFF;
	localparam logic [11:0] MAX_COLS_RESET = 12'd4095;

	// What one parse step produced
	typedef struct packed {
		logic        pt_valid;
		logic        st_valid;
		logic        st_ok;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] color;
	} parse_res_t;

	// One result word as it sits in the output queue
	typedef struct packed {
		logic        kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] color;
		logic        ok;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/hmltp_parse.sv
// Per-character parse state machine and point arithmetic for one text line.
// Depends on hmltp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hmltp_parse import hmltp_pkg::*; #(
	parameter int unsigned SCALE_FACTOR = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_en,
	input  wire logic        kind,
	input  wire logic [7:0]  char_code,
	input  wire logic [11:0] row,
	input  wire logic [11:0] max_columns,
	output parse_res_t       res
);

	localparam logic [31:0] ScaleW = 32'(SCALE_FACTOR);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_HEIGHT = 3'b010,
		PH_SUFFIX = 3'b100
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] height_q, height_d;
	logic        neg_q, neg_d;
	logic        hstop_q, hstop_d;
	logic [31:0] color_q, color_d;
	logic [3:0]  scount_q, scount_d;
	logic        xstop_q, xstop_d;
	logic [12:0] col_q, col_d;
	logic [31:0] xacc_q, xacc_d;
	logic        err_q, err_d;
	logic        full_q, full_d;

	logic        is_dig, is_hexc;
	logic [3:0]  hexv;
	logic [31:0] hval, dflt, emit_color;
	logic [12:0] col_inc;
	logic        emit, status, set_err, past_max;

	assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_hexc = is_dig || ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F));
	assign hexv    = is_dig ? char_code[3:0] : 4'(char_code - CH_UPPER_A + 8'd10);
	assign hval    = neg_q ? (32'd0 - height_q) : height_q;
	// 0x808 * h as shifts
	assign dflt    = COLOR_WHITE - ((hval << 11) + (hval << 3));
	assign col_inc = col_q + 13'd1;
	assign past_max = col_inc > {1'b0, max_columns};

	always_comb begin
		phase_d  = phase_q;
		height_d = height_q;
		neg_d    = neg_q;
		hstop_d  = hstop_q;
		color_d  = color_q;
		scount_d = scount_q;
		xstop_d  = xstop_q;
		col_d    = col_q;
		xacc_d   = xacc_q;
		err_d    = err_q;
		full_d   = full_q;
		emit       = 1'b0;
		emit_color = dflt;
		status     = 1'b0;
		set_err    = 1'b0;

		if (kind == KIND_TEXT) begin
			if (!err_q && !full_q) begin
				unique case (phase_q)
					PH_IDLE: begin
						if (char_code == CH_SPACE) begin
							phase_d = PH_IDLE;
						end else if (is_dig || char_code == CH_MINUS) begin
							neg_d    = (char_code == CH_MINUS);
							height_d = is_dig ? {28'd0, char_code[3:0]} : 32'd0;
							hstop_d  = 1'b0;
							phase_d  = PH_HEIGHT;
						end else begin
							set_err = 1'b1;
						end
					end
					PH_HEIGHT: begin
						if (is_dig) begin
							if (!hstop_q) begin
								height_d = (height_q << 3) + (height_q << 1)
									+ {28'd0, char_code[3:0]};
							end
						end else if (char_code == CH_MINUS) begin
							hstop_d = 1'b1;
						end else if (char_code == CH_SPACE) begin
							emit = 1'b1;
						end else if (char_code == CH_COMMA) begin
							phase_d  = PH_SUFFIX;
							scount_d = 4'd1;
							color_d  = 32'd0;
							xstop_d  = 1'b0;
						end else if (past_max) begin
							// stray character ends the token that fills the line
							emit = 1'b1;
						end else begin
							set_err = 1'b1;
						end
					end
					PH_SUFFIX: begin
						if (char_code == CH_SPACE) begin
							if (scount_q == SUFFIX_LEN) begin
								emit       = 1'b1;
								emit_color = color_q;
							end else begin
								set_err = 1'b1;
							end
						end else if (char_code == CH_COMMA || char_code == CH_LOWER_X
								|| is_hexc) begin
							if (scount_q >= SUFFIX_LEN) begin
								set_err = 1'b1;
							end else begin
								if (scount_q >= HEX_START && !xstop_q) begin
									if (is_hexc) begin
										color_d = (color_q << 4) + {28'd0, hexv};
									end else begin
										xstop_d = 1'b1;
									end
								end
								scount_d = scount_q + 4'd1;
							end
						end else begin
							set_err = 1'b1;
						end
					end
					default: set_err = 1'b1;
				endcase
			end
		end else begin
			if (!err_q && !full_q) begin
				if (phase_q == PH_HEIGHT) begin
					emit = 1'b1;
				end else if (phase_q == PH_SUFFIX) begin
					if (scount_q == SUFFIX_LEN) begin
						emit       = 1'b1;
						emit_color = color_q;
					end else begin
						set_err = 1'b1;
					end
				end
			end
			status = 1'b1;
		end

		if (set_err) begin
			err_d   = 1'b1;
			phase_d = PH_IDLE;
		end
		if (emit) begin
			col_d   = col_inc;
			xacc_d  = xacc_q + ScaleW;
			phase_d = PH_IDLE;
			if (past_max) begin
				full_d = 1'b1;
			end
		end

		res.pt_valid = emit;
		res.st_valid = status;
		res.st_ok    = !err_d;
		res.x        = xacc_q;
		res.y        = 32'(row) * ScaleW;
		res.z        = hval * ScaleW;
		res.color    = emit_color;

		// end of line: return the line state to reset
		if (status) begin
			phase_d  = PH_IDLE;
			height_d = 32'd0;
			neg_d    = 1'b0;
			hstop_d  = 1'b0;
			color_d  = 32'd0;
			scount_d = 4'd0;
			xstop_d  = 1'b0;
			col_d    = 13'd0;
			xacc_d   = 32'd0;
			err_d    = 1'b0;
			full_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			height_q <= '0;
			neg_q    <= 1'b0;
			hstop_q  <= 1'b0;
			color_q  <= '0;
			scount_q <= '0;
			xstop_q  <= 1'b0;
			col_q    <= '0;
			xacc_q   <= '0;
			err_q    <= 1'b0;
			full_q   <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			height_q <= height_d;
			neg_q    <= neg_d;
			hstop_q  <= hstop_d;
			color_q  <= color_d;
			scount_q <= scount_d;
			xstop_q  <= xstop_d;
			col_q    <= col_d;
			xacc_q   <= xacc_d;
			err_q    <= err_d;
			full_q   <= full_d;
		end
	end

	// an errored line stops before it can fill, and a full line takes no error
	`HMLTP_NEVER(a_err_and_full, clk, arst_n, err_q && full_q, "line both errored and full")

endmodule

`default_nettype wire

FILE: rtl/core/heightmap_line_token_parser_unit.sv
// Top level of the height map line token parser: input stage, parser, result queue.
// Depends on hmltp_pkg, hmltp_parse and assert_macros.svh.
//
// The block takes one character word of a height map text line per cycle while
// the result queue has room, and returns point words (x = column*SCALE_FACTOR,
// y = row*SCALE_FACTOR, z = height*SCALE_FACTOR, color) and, at end of line, one
// status word with line_ok. A word is accepted into an input register; the parser
// updates its line state from that register and pushes zero, one or two result
// words into a four-word result queue whose head drives the output ports. With
// the output side always ready the block sustains one input word per cycle; an
// end of line that flushes a pending point yields two result words, and the input
// stage holds whenever the queue has fewer than two free entries, so the queue
// drain rate of one word per cycle sets the figure for bursts of such end-of-line
// words. A result shows at the outputs once the parser has written it from the
// input register into the queue. max_columns is written through the cfg channel,
// which is always ready; write it only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module heightmap_line_token_parser_unit import hmltp_pkg::*; #(
	parameter int unsigned SCALE_FACTOR = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write channel
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [11:0]        cfg_data,
	// input channel
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         char_code,
	input  wire logic [11:0]        row,
	// output channel
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               result_kind,
	output      logic signed [31:0] x_pos,
	output      logic signed [31:0] y_pos,
	output      logic signed [31:0] z_pos,
	output      logic [31:0]        color,
	output      logic               line_ok,
	output      logic               last
);

	localparam int unsigned PtrW = $clog2(ResultQueueDepth);
	localparam int unsigned CntW = $clog2(ResultQueueDepth + 1);

	// configuration register
	logic [11:0] max_columns_q;

	// input stage
	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  char_s1;
	logic [11:0] row_s1;
	logic        fire;

	// result queue
	result_t         queue_q [ResultQueueDepth];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] n_push;
	logic            pop;
	logic            room2;
	result_t         word_a, word_b;
	result_t         head;

	parse_res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_columns_q <= MAX_COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_columns_q <= cfg_data;
		end
	end

	// advance the input register only when the queue can take two words
	assign room2    = count_q <= CntW'(ResultQueueDepth - 2);
	assign fire     = valid_s1 && room2;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			char_s1 <= char_code;
			row_s1  <= row;
		end
	end

	hmltp_parse #(
		.SCALE_FACTOR(SCALE_FACTOR)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (fire),
		.kind       (kind_s1),
		.char_code  (char_s1),
		.row        (row_s1),
		.max_columns(max_columns_q),
		.res        (res)
	);

	// build the result words: a flushed point comes before the line status
	always_comb begin
		word_a.kind  = RES_POINT;
		word_a.x     = res.x;
		word_a.y     = res.y;
		word_a.z     = res.z;
		word_a.color = res.color;
		word_a.ok    = 1'b0;
		word_a.last  = !res.st_valid;

		word_b.kind  = RES_STATUS;
		word_b.x     = 32'd0;
		word_b.y     = 32'd0;
		word_b.z     = 32'd0;
		word_b.color = 32'd0;
		word_b.ok    = res.st_ok;
		word_b.last  = 1'b1;

		n_push = CntW'(res.pt_valid) + CntW'(res.st_valid);
		if (!fire) begin
			n_push = '0;
		end
	end

	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PtrW'(n_push);
			rptr_q  <= rptr_q + PtrW'(pop);
			count_q <= count_q + n_push - CntW'(pop);
		end
	end

	// write one or two words; the status word follows the point when both come
	always_ff @(posedge clk) begin
		if (fire) begin
			if (res.pt_valid) begin
				queue_q[wptr_q] <= word_a;
				if (res.st_valid) begin
					queue_q[wptr_q + PtrW'(1)] <= word_b;
				end
			end else if (res.st_valid) begin
				queue_q[wptr_q] <= word_b;
			end
		end
	end

	assign head        = queue_q[rptr_q];
	assign out_valid   = count_q != '0;
	assign result_kind = head.kind;
	assign x_pos       = $signed(head.x);
	assign y_pos       = $signed(head.y);
	assign z_pos       = $signed(head.z);
	assign color       = head.color;
	assign line_ok     = head.ok;
	assign last        = head.last;

	`HMLTP_NEVER(a_queue_overflow, clk, arst_n,
		count_q > CntW'(ResultQueueDepth), "result queue overflow")
	`HMLTP_ASSERT(a_eol_status, clk, arst_n,
		(fire && kind_s1 == KIND_EOL) |-> (res.st_valid && n_push != '0),
		"end of line without status")
	`HMLTP_ASSERT(a_status_last, clk, arst_n,
		(out_valid && result_kind == RES_STATUS) |-> last, "status word not marked last")

endmodule

`default_nettype wire
